[src/gbb_pkg.sv]
// Shared types and constants for the bidirectional BFS graph store.
// No dependencies; gbb_core and the top level import this package.
`timescale 1ns / 1ps
package gbb_pkg;

  localparam int NODE_COUNT   = 1024;
  localparam int BUCKET_SLOTS = 8;
  localparam int BUCKET_COUNT = 2048;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int BKT_W  = $clog2(BUCKET_COUNT);
  localparam int HEAD_W = BKT_W + 1;
  localparam int SLOT_W = $clog2(BUCKET_SLOTS);
  localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
  localparam int HF_W   = HEAD_W + FILL_W;
  localparam int SADR_W = BKT_W + SLOT_W;
  localparam int QC_W   = NODE_W + 1;
  localparam int LVL_W  = 12;
  localparam int DIST_W = 11;

  localparam logic [HEAD_W-1:0] NO_BUCKET = HEAD_W'(BUCKET_COUNT);

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic signed [DIST_W-1:0] DIST_NONE = -11'sd1;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [1:0]               status;
  } out_item_t;

endpackage

[src/gbb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/gbb_core.sv]
// Sequencer, adjacency stores, visited maps and frontier queues.
// Depends on gbb_pkg and gbb_ram. One slot compare unit serves insert and search.
`timescale 1ns / 1ps
module gbb_core
  import gbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  output logic      idle_o,
  output logic      done_valid_o,
  input  logic      done_ready_i,
  output out_item_t res_o
);

  typedef enum logic [14:0] {
    ST_CLR_HD   = 15'b000000000000001,
    ST_IDLE     = 15'b000000000000010,
    ST_ADD_HD   = 15'b000000000000100,
    ST_WALK_RD  = 15'b000000000001000,
    ST_WALK_CMP = 15'b000000000010000,
    ST_ADD_DEC  = 15'b000000000100000,
    ST_Q_CLR    = 15'b000000001000000,
    ST_Q_INIT   = 15'b000000010000000,
    ST_LOOP     = 15'b000000100000000,
    ST_LAYER    = 15'b000001000000000,
    ST_POP      = 15'b000010000000000,
    ST_HD       = 15'b000100000000000,
    ST_SEEN     = 15'b001000000000000,
    ST_DONE     = 15'b010000000000000,
    ST_SPARE    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic [HEAD_W-1:0] fused_q, fused_d, rused_q, rused_d;
  logic mode_q, mode_d, side_q, side_d;
  logic [NODE_W-1:0] src_q, src_d, dst_q, dst_d, nb_q, nb_d;
  logic [HEAD_W-1:0] fh_q, fh_d, rh_q, rh_d, b_q, b_d, link_q, link_d;
  logic [FILL_W-1:0] ff_q, ff_d, rf_q, rf_d, n_q, n_d, i_q, i_d;
  logic [NODE_W-1:0] fqh_q, fqh_d, rqh_q, rqh_d;
  logic [QC_W-1:0]   fqc_q, fqc_d, rqc_q, rqc_d, k_q, k_d, layer_q, layer_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  out_item_t         res_q, res_d;

  // RAM ports
  logic fhd_we, rhd_we, fnd_we, rnd_we, flk_we, rlk_we, fsn_we, rsn_we, fq_we, rq_we;
  logic [NODE_W-1:0] fhd_wa, rhd_wa, fhd_ra, rhd_ra;
  logic [HF_W-1:0]   fhd_wd, rhd_wd, fhd_rd, rhd_rd;
  logic [SADR_W-1:0] fnd_wa, rnd_wa, nd_ra;
  logic [NODE_W-1:0] fnd_wd, rnd_wd, fnd_rd, rnd_rd;
  logic [BKT_W-1:0]  flk_wa, rlk_wa;
  logic [HEAD_W-1:0] flk_wd, rlk_wd, flk_rd, rlk_rd;
  logic [NODE_W-1:0] fsn_wa, rsn_wa, sn_ra;
  logic [0:0]        fsn_wd, rsn_wd, fsn_rd, rsn_rd;
  logic [NODE_W-1:0] fq_wa, rq_wa, fq_wd, rq_wd, fq_rd, rq_rd;

  // side-muxed read data
  logic [HF_W-1:0]   hd_rd;
  logic [NODE_W-1:0] nd_rd;
  logic [HEAD_W-1:0] lk_rd, link_cur;
  logic              mine_rd, oth_rd;
  logic [FILL_W-1:0] i_nx;
  logic              last_slot;
  logic              fneed, rneed, full;
  logic [HEAD_W-1:0] fnh, rnh;
  logic [FILL_W-1:0] fnf, rnf;
  logic              push;

  assign hd_rd   = side_q ? rhd_rd : fhd_rd;
  assign nd_rd   = side_q ? rnd_rd : fnd_rd;
  assign lk_rd   = side_q ? rlk_rd : flk_rd;
  assign mine_rd = side_q ? rsn_rd[0] : fsn_rd[0];
  assign oth_rd  = side_q ? fsn_rd[0] : rsn_rd[0];

  assign link_cur  = (state_q == ST_WALK_CMP) ? lk_rd : link_q;
  assign i_nx      = i_q + FILL_W'(1);
  assign last_slot = (i_nx >= n_q);

  assign fneed = (fh_q >= NO_BUCKET) || (ff_q >= FILL_W'(BUCKET_SLOTS));
  assign rneed = (rh_q >= NO_BUCKET) || (rf_q >= FILL_W'(BUCKET_SLOTS));
  assign full  = (fneed && (fused_q >= NO_BUCKET)) || (rneed && (rused_q >= NO_BUCKET));
  assign fnh   = fneed ? fused_q : fh_q;
  assign rnh   = rneed ? rused_q : rh_q;
  assign fnf   = fneed ? '0 : ff_q;
  assign rnf   = rneed ? '0 : rf_q;
  assign push  = (state_q == ST_SEEN) && !mine_rd && !oth_rd;

  // read addresses
  assign fhd_ra = (state_q == ST_IDLE) ? item_i.src_node : fq_rd;
  assign rhd_ra = (state_q == ST_IDLE) ? item_i.dst_node : rq_rd;
  assign nd_ra  = {b_q[BKT_W-1:0], i_q[SLOT_W-1:0]};
  assign sn_ra  = nd_rd;

  // write ports
  always_comb begin
    fhd_we = 1'b0; rhd_we = 1'b0; fnd_we = 1'b0; rnd_we = 1'b0;
    flk_we = 1'b0; rlk_we = 1'b0; fsn_we = 1'b0; rsn_we = 1'b0;
    fq_we  = 1'b0; rq_we  = 1'b0;
    fhd_wa = cnt_q; rhd_wa = cnt_q;
    fhd_wd = {NO_BUCKET, FILL_W'(0)}; rhd_wd = {NO_BUCKET, FILL_W'(0)};
    fnd_wa = {fnh[BKT_W-1:0], fnf[SLOT_W-1:0]};
    rnd_wa = {rnh[BKT_W-1:0], rnf[SLOT_W-1:0]};
    fnd_wd = dst_q; rnd_wd = src_q;
    flk_wa = fused_q[BKT_W-1:0]; rlk_wa = rused_q[BKT_W-1:0];
    flk_wd = fh_q; rlk_wd = rh_q;
    fsn_wa = cnt_q; rsn_wa = cnt_q; fsn_wd = 1'b0; rsn_wd = 1'b0;
    fq_wa  = NODE_W'(fqh_q + fqc_q[NODE_W-1:0]);
    rq_wa  = NODE_W'(rqh_q + rqc_q[NODE_W-1:0]);
    fq_wd  = nb_q; rq_wd = nb_q;
    unique case (state_q)
      ST_CLR_HD: begin
        fhd_we = 1'b1;
        rhd_we = 1'b1;
      end
      ST_ADD_DEC: begin
        if (!full) begin
          fhd_we = 1'b1; fhd_wa = src_q; fhd_wd = {fnh, fnf + FILL_W'(1)};
          rhd_we = 1'b1; rhd_wa = dst_q; rhd_wd = {rnh, rnf + FILL_W'(1)};
          fnd_we = 1'b1; rnd_we = 1'b1;
          flk_we = fneed; rlk_we = rneed;
        end
      end
      ST_Q_CLR: begin
        fsn_we = 1'b1;
        rsn_we = 1'b1;
      end
      ST_Q_INIT: begin
        fsn_we = 1'b1; fsn_wa = src_q; fsn_wd = 1'b1;
        rsn_we = 1'b1; rsn_wa = dst_q; rsn_wd = 1'b1;
        fq_we = 1'b1; fq_wa = '0; fq_wd = src_q;
        rq_we = 1'b1; rq_wa = '0; rq_wd = dst_q;
      end
      ST_SEEN: begin
        fsn_wa = nb_q; rsn_wa = nb_q; fsn_wd = 1'b1; rsn_wd = 1'b1;
        fsn_we = push && !side_q; fq_we = push && !side_q;
        rsn_we = push && side_q;  rq_we = push && side_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; fused_d = fused_q; rused_d = rused_q;
    mode_d = mode_q; side_d = side_q; src_d = src_q; dst_d = dst_q; nb_d = nb_q;
    fh_d = fh_q; rh_d = rh_q; ff_d = ff_q; rf_d = rf_q;
    b_d = b_q; n_d = n_q; i_d = i_q; link_d = link_q;
    fqh_d = fqh_q; rqh_d = rqh_q; fqc_d = fqc_q; rqc_d = rqc_q;
    k_d = k_q; layer_d = layer_q; lvl_d = lvl_q; res_d = res_q;
    unique case (state_q)
      ST_CLR_HD: begin
        cnt_d = cnt_q + NODE_W'(1);
        if (cnt_q == NODE_W'(NODE_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          mode_d = item_i.func;
          src_d  = item_i.src_node;
          dst_d  = item_i.dst_node;
          side_d = 1'b0;
          res_d  = '{distance: '0, status: STAT_OK};
          cnt_d  = '0;
          if (item_i.func == FUNC_ADD) state_d = ST_ADD_HD;
          else if (item_i.src_node == item_i.dst_node) state_d = ST_DONE;
          else state_d = ST_Q_CLR;
        end
      end
      ST_ADD_HD: begin
        fh_d = fhd_rd[HF_W-1:FILL_W]; ff_d = fhd_rd[FILL_W-1:0];
        rh_d = rhd_rd[HF_W-1:FILL_W]; rf_d = rhd_rd[FILL_W-1:0];
        b_d = fhd_rd[HF_W-1:FILL_W]; n_d = fhd_rd[FILL_W-1:0]; i_d = '0;
        state_d = (fhd_rd[HF_W-1:FILL_W] >= NO_BUCKET) ? ST_ADD_DEC : ST_WALK_RD;
      end
      ST_WALK_RD: state_d = ST_WALK_CMP;
      ST_WALK_CMP, ST_SEEN: begin
        if (state_q == ST_WALK_CMP) begin
          link_d = lk_rd;
          nb_d   = nd_rd;
        end
        if (state_q == ST_WALK_CMP && mode_q == FUNC_ADD && i_q < n_q && nd_rd == dst_q) begin
          res_d.status = STAT_DUP;
          state_d = ST_DONE;
        end else if (state_q == ST_WALK_CMP && mode_q == FUNC_QUERY && i_q < n_q) begin
          state_d = ST_SEEN;
        end else if (state_q == ST_SEEN && !mine_rd && oth_rd) begin
          res_d.distance = lvl_q[DIST_W-1:0];
          state_d = ST_DONE;
        end else begin
          if (push) begin
            if (side_q) rqc_d = rqc_q + QC_W'(1);
            else        fqc_d = fqc_q + QC_W'(1);
          end
          if (!last_slot) begin
            i_d = i_nx;
            state_d = ST_WALK_RD;
          end else if (link_cur >= NO_BUCKET) begin
            state_d = (mode_q == FUNC_ADD) ? ST_ADD_DEC : ST_LAYER;
          end else begin
            b_d = link_cur;
            n_d = FILL_W'(BUCKET_SLOTS);
            i_d = '0;
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_ADD_DEC: begin
        if (full) begin
          res_d.status = STAT_FULL;
        end else begin
          if (fneed) fused_d = fused_q + HEAD_W'(1);
          if (rneed) rused_d = rused_q + HEAD_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_Q_CLR: begin
        cnt_d = cnt_q + NODE_W'(1);
        if (cnt_q == NODE_W'(NODE_COUNT - 1)) state_d = ST_Q_INIT;
      end
      ST_Q_INIT: begin
        fqh_d = '0; rqh_d = '0;
        fqc_d = QC_W'(1); rqc_d = QC_W'(1);
        lvl_d = LVL_W'(1);
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (fqc_q == '0 || rqc_q == '0) begin
          res_d.distance = DIST_NONE;
          state_d = ST_DONE;
        end else begin
          side_d  = (rqc_q < fqc_q);
          layer_d = (rqc_q < fqc_q) ? rqc_q : fqc_q;
          k_d     = '0;
          state_d = ST_LAYER;
        end
      end
      ST_LAYER: begin
        if (k_q == layer_q) begin
          lvl_d = lvl_q + LVL_W'(1);
          state_d = ST_LOOP;
        end else begin
          k_d = k_q + QC_W'(1);
          if (side_q) begin
            rqh_d = rqh_q + NODE_W'(1); rqc_d = rqc_q - QC_W'(1);
          end else begin
            fqh_d = fqh_q + NODE_W'(1); fqc_d = fqc_q - QC_W'(1);
          end
          state_d = ST_POP;
        end
      end
      ST_POP: state_d = ST_HD;
      ST_HD: begin
        b_d = hd_rd[HF_W-1:FILL_W]; n_d = hd_rd[FILL_W-1:0]; i_d = '0;
        state_d = (hd_rd[HF_W-1:FILL_W] >= NO_BUCKET) ? ST_LAYER : ST_WALK_RD;
      end
      ST_DONE: begin
        if (done_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_HD;
      cnt_q   <= '0;
      fused_q <= '0;
      rused_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fused_q <= fused_d;
      rused_q <= rused_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; side_q <= side_d; src_q <= src_d; dst_q <= dst_d; nb_q <= nb_d;
    fh_q <= fh_d; rh_q <= rh_d; ff_q <= ff_d; rf_q <= rf_d;
    b_q <= b_d; n_q <= n_d; i_q <= i_d; link_q <= link_d;
    fqh_q <= fqh_d; rqh_q <= rqh_d; fqc_q <= fqc_d; rqc_q <= rqc_d;
    k_q <= k_d; layer_q <= layer_d; lvl_q <= lvl_d; res_q <= res_d;
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign done_valid_o = (state_q == ST_DONE);
  assign res_o        = res_q;

  gbb_ram #(.Width(HF_W), .Depth(NODE_COUNT)) u_fhd (
    .clk_i, .we_i(fhd_we), .waddr_i(fhd_wa), .wdata_i(fhd_wd), .raddr_i(fhd_ra), .rdata_o(fhd_rd)
  );
  gbb_ram #(.Width(HF_W), .Depth(NODE_COUNT)) u_rhd (
    .clk_i, .we_i(rhd_we), .waddr_i(rhd_wa), .wdata_i(rhd_wd), .raddr_i(rhd_ra), .rdata_o(rhd_rd)
  );
  gbb_ram #(.Width(NODE_W), .Depth(BUCKET_COUNT * BUCKET_SLOTS)) u_fnd (
    .clk_i, .we_i(fnd_we), .waddr_i(fnd_wa), .wdata_i(fnd_wd), .raddr_i(nd_ra), .rdata_o(fnd_rd)
  );
  gbb_ram #(.Width(NODE_W), .Depth(BUCKET_COUNT * BUCKET_SLOTS)) u_rnd (
    .clk_i, .we_i(rnd_we), .waddr_i(rnd_wa), .wdata_i(rnd_wd), .raddr_i(nd_ra), .rdata_o(rnd_rd)
  );
  gbb_ram #(.Width(HEAD_W), .Depth(BUCKET_COUNT)) u_flk (
    .clk_i, .we_i(flk_we), .waddr_i(flk_wa), .wdata_i(flk_wd),
    .raddr_i(b_q[BKT_W-1:0]), .rdata_o(flk_rd)
  );
  gbb_ram #(.Width(HEAD_W), .Depth(BUCKET_COUNT)) u_rlk (
    .clk_i, .we_i(rlk_we), .waddr_i(rlk_wa), .wdata_i(rlk_wd),
    .raddr_i(b_q[BKT_W-1:0]), .rdata_o(rlk_rd)
  );
  gbb_ram #(.Width(1), .Depth(NODE_COUNT)) u_fsn (
    .clk_i, .we_i(fsn_we), .waddr_i(fsn_wa), .wdata_i(fsn_wd), .raddr_i(sn_ra), .rdata_o(fsn_rd)
  );
  gbb_ram #(.Width(1), .Depth(NODE_COUNT)) u_rsn (
    .clk_i, .we_i(rsn_we), .waddr_i(rsn_wa), .wdata_i(rsn_wd), .raddr_i(sn_ra), .rdata_o(rsn_rd)
  );
  gbb_ram #(.Width(NODE_W), .Depth(NODE_COUNT)) u_fq (
    .clk_i, .we_i(fq_we), .waddr_i(fq_wa), .wdata_i(fq_wd), .raddr_i(fqh_q), .rdata_o(fq_rd)
  );
  gbb_ram #(.Width(NODE_W), .Depth(NODE_COUNT)) u_rq (
    .clk_i, .we_i(rq_we), .waddr_i(rq_wa), .wdata_i(rq_wd), .raddr_i(rqh_q), .rdata_o(rq_rd)
  );

  // each node enters a frontier at most once per query
  a_fqc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAYER) |-> (fqc_q <= QC_W'(NODE_COUNT)))
    else $error("forward frontier overflow");

  a_push_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !side_q) |=> (fqc_q == $past(fqc_q) + QC_W'(1)))
    else $error("forward push lost");

  a_stat_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_valid_o && res_q.status != STAT_OK) |-> (mode_q == FUNC_ADD))
    else $error("edge status on a query");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fused_q <= NO_BUCKET) && (rused_q <= NO_BUCKET))
    else $error("bucket count beyond store");

endmodule

[src/graph_store_bidirectional_bfs.sv]
// Top level: input handshake, output register, and the search core.
// Depends on gbb_pkg and gbb_core.
//
//  port group   dir  handshake               payload
//  in_*         in   in_valid_i/in_ready_o   in_item_t  (func, src_node, dst_node)
//  out_*        out  out_valid_o/out_ready_i out_item_t (distance, status)
//
// After reset both head tables are swept, one node per cycle, and the input is not ready.
// Add edge: the source's forward chain is scanned slot by slot for a duplicate.
// Query: the visited maps are cleared, then each layer pops its nodes and scans
// their neighbour slots; the single slot compare unit sets the pace.
// One item at a time; the next is taken once the result is in the output register.
`timescale 1ns / 1ps
module graph_store_bidirectional_bfs
  import gbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      idle, done_valid, done_ready;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  assign done_ready  = done_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = done_ready || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ready) begin
      out_q <= res;
    end
  end

  assign in_ready_o  = idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gbb_core u_core (
    .clk_i,
    .rst_ni,
    .start_i     (in_valid_i && idle),
    .item_i      (in_data_i),
    .idle_o      (idle),
    .done_valid_o(done_valid),
    .done_ready_i(done_ready),
    .res_o       (res)
  );

endmodule
